[design/broadcast_ring_buffer_assert.svh]
// Assertion macros for the checker file of the ring buffer.
`ifndef BROADCAST_RING_BUFFER_ASSERT_SVH
`define BROADCAST_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BRB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("broadcast ring buffer: check failed");

// Next-cycle implication, disabled while reset is low.
`define BRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("broadcast ring buffer: check failed");

`endif

[design/brb_pkg.sv]
package brb_pkg;

    // Default sizes of the ring and of the reader table.
    localparam int DEF_BUF_DEPTH   = 256;
    localparam int DEF_NUM_READERS = 8;

    // Fixed field widths.
    localparam int OP_W     = 2;
    localparam int READER_W = 3;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int HEAD_W   = 32;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_AVAIL = 2'd1,
        OP_READ  = 2'd2,
        OP_PEEK  = 2'd3
    } t_op;

    // One classified request as it waits in the queue.
    typedef struct packed {
        t_op                 op;
        logic [READER_W-1:0] reader;
        logic [DATA_W-1:0]   data;
        logic                in_range;
    } t_item;

endpackage

[design/brb_front.sv]
module brb_front #(
    parameter int NUM_READERS = brb_pkg::DEF_NUM_READERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [brb_pkg::OP_W-1:0]      i_op,
    input  logic [brb_pkg::READER_W-1:0]  i_reader,
    input  logic [brb_pkg::DATA_W-1:0]    i_data,
    output logic                          o_item_valid,
    output brb_pkg::t_item                o_item,
    input  logic                          i_pop
);

    // Two-entry queue between the port and the execution side.
    brb_pkg::t_item r_q [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_cnt, n_cnt;
    brb_pkg::t_item w_new;
    logic           w_push;
    logic           w_pop;

    // Classify the incoming request: decode the code, check the reader slot.
    always_comb begin
        w_new.op       = brb_pkg::t_op'(i_op);
        w_new.reader   = i_reader;
        w_new.data     = i_data;
        w_new.in_range = (32'(i_reader) < 32'(NUM_READERS));
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_new;
        end
    end

endmodule

[design/brb_back.sv]
module brb_back #(
    parameter int BUF_DEPTH   = brb_pkg::DEF_BUF_DEPTH,
    parameter int NUM_READERS = brb_pkg::DEF_NUM_READERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  brb_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [brb_pkg::DATA_W-1:0]    o_data,
    output logic                          o_empty,
    output logic [brb_pkg::COUNT_W-1:0]   o_count
);

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int CW    = $clog2(BUF_DEPTH + 1);
    localparam int IW    = AW + 2;
    localparam int IDX_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
    localparam logic [brb_pkg::HEAD_W-1:0] DEPTH_H = brb_pkg::HEAD_W'(BUF_DEPTH);
    localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
    localparam logic [IW-1:0] DEPTH2_I = IW'(2 * BUF_DEPTH);
    localparam longint unsigned WRAP_OFS_L = (64'd1 << 32) % BUF_DEPTH;
    localparam logic [IW-1:0] WRAP_OFS = IW'(WRAP_OFS_L);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_DATA = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Writer head: full 32-bit count and its position in the ring.
    logic [brb_pkg::HEAD_W-1:0] r_head, n_head;
    logic [AW-1:0]              r_head_idx, n_head_idx;

    // Reader table.
    logic [brb_pkg::HEAD_W-1:0] r_cur [NUM_READERS];
    logic [NUM_READERS-1:0]     r_reg;

    // Ring memory and its registered read port.
    logic [brb_pkg::DATA_W-1:0] r_mem [BUF_DEPTH];
    logic [brb_pkg::DATA_W-1:0] r_rd_data;

    // Result waiting for the ring read.
    logic                        r_pend_byte;
    logic                        r_pend_empty;
    logic [brb_pkg::COUNT_W-1:0] r_pend_count;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [brb_pkg::DATA_W-1:0]  r_out_data;
    logic                        r_out_empty;
    logic [brb_pkg::COUNT_W-1:0] r_out_count;

    logic                       w_is_push;
    logic                       w_out_free;
    logic                       w_take;
    logic                       w_query;
    logic [IDX_W-1:0]           w_idx;
    logic [brb_pkg::HEAD_W-1:0] w_cur_base;
    logic [brb_pkg::HEAD_W-1:0] w_behind_h;
    logic                       w_lapped;
    logic [CW-1:0]              w_behind;
    logic [brb_pkg::HEAD_W-1:0] w_cur_set;
    logic [brb_pkg::HEAD_W-1:0] w_cur_next;
    logic                       w_has_byte;
    logic                       w_empty;
    logic [CW-1:0]              w_count;
    logic                       w_wrapped;
    logic [IW-1:0]              w_pos;
    logic [IW-1:0]              w_pos_red;
    logic [AW-1:0]              w_rd_idx;

    assign w_is_push  = (i_item.op == brb_pkg::OP_PUSH);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_take     = (r_state == ST_RUN) && i_item_valid && (w_is_push || w_out_free);
    assign w_query    = w_take && !w_is_push;
    assign o_pop      = w_take;
    assign w_idx      = IDX_W'(i_item.reader);

    // Settle the reader: register on first use, clamp when lapped.
    always_comb begin
        w_cur_base = r_reg[w_idx] ? r_cur[w_idx] : r_head;
        w_behind_h = r_head - w_cur_base;
        w_lapped   = (w_behind_h > DEPTH_H);
        w_behind   = w_lapped ? CW'(BUF_DEPTH) : w_behind_h[CW-1:0];
        w_cur_set  = w_lapped ? (r_head - DEPTH_H) : w_cur_base;
    end

    // Result fields and the cursor after the request.
    always_comb begin
        w_has_byte = i_item.in_range && (w_behind != '0)
                     && (i_item.op != brb_pkg::OP_AVAIL);
        w_empty    = !i_item.in_range || (w_behind == '0);
        if (!i_item.in_range) begin
            w_count = '0;
        end else if ((i_item.op == brb_pkg::OP_READ) && (w_behind != '0)) begin
            w_count = w_behind - CW'(1);
        end else begin
            w_count = w_behind;
        end
        if ((i_item.op == brb_pkg::OP_READ) && w_has_byte) begin
            w_cur_next = w_cur_set + brb_pkg::HEAD_W'(1);
        end else begin
            w_cur_next = w_cur_set;
        end
    end

    // Ring position of the cursor: head position minus the unread count,
    // plus the 32-bit wrap offset when the cursor lies across the wrap.
    always_comb begin
        w_wrapped = (r_head < brb_pkg::HEAD_W'(w_behind));
        w_pos     = IW'(r_head_idx) + (w_wrapped ? WRAP_OFS : '0) + DEPTH_I
                    - IW'(w_behind);
        if (w_pos >= DEPTH2_I) begin
            w_pos_red = w_pos - DEPTH2_I;
        end else if (w_pos >= DEPTH_I) begin
            w_pos_red = w_pos - DEPTH_I;
        end else begin
            w_pos_red = w_pos;
        end
        w_rd_idx = w_pos_red[AW-1:0];
    end

    // Head advance; the ring position wraps after its last index and restarts when the 32-bit head wraps.
    always_comb begin
        n_head     = r_head;
        n_head_idx = r_head_idx;
        if (w_take && w_is_push) begin
            n_head = r_head + brb_pkg::HEAD_W'(1);
            if ((r_head == '1) || (r_head_idx == LAST_IDX)) begin
                n_head_idx = '0;
            end else begin
                n_head_idx = r_head_idx + AW'(1);
            end
        end
    end

    // Sequencer: a query moves to ST_DATA while the registered ring read completes.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_query) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Output valid: cleared when taken, set when a result is loaded.
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (r_state == ST_DATA) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_head      <= '0;
            r_head_idx  <= '0;
            r_reg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_head_idx  <= n_head_idx;
            r_out_valid <= n_out_valid;
            if (w_query && i_item.in_range) begin
                r_reg[w_idx] <= 1'b1;
            end
        end
    end

    // Cursor table update.
    always_ff @(posedge i_clk) begin
        if (w_query && i_item.in_range) begin
            r_cur[w_idx] <= w_cur_next;
        end
    end

    // Ring memory: one write port for pushes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_take && w_is_push) begin
            r_mem[r_head_idx] <= i_item.data;
        end
        if (w_query && w_has_byte) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    // Pending result and output register payload.
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_pend_byte  <= w_has_byte;
            r_pend_empty <= w_empty;
            r_pend_count <= brb_pkg::COUNT_W'(w_count);
        end
        if (r_state == ST_DATA) begin
            r_out_data  <= r_pend_byte ? r_rd_data : '0;
            r_out_empty <= r_pend_empty;
            r_out_count <= r_pend_count;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_empty = r_out_empty;
    assign o_count = r_out_count;

endmodule

[design/broadcast_ring_buffer.sv]
// Byte ring buffer with one writer and up to eight independent readers. A push
// (op 0) stores a byte and overwrites the oldest one once the ring is full; it
// gives no response. Available, read and peek (op 1..3) give one response each:
// the byte at the reader's cursor, an empty flag and the unread count. A reader
// registers on its first request and then sees an empty buffer; a reader that
// has been lapped restarts at the oldest byte still held. Requests enter a
// two-entry queue. A push is taken in the run state; a query moves to a data
// state for the registered read of the ring memory. Pushes go at one per cycle
// outside that state; a new query waits for the run state and a free response
// register. The ring memory needs no clearing after reset; requests are taken at once.
module broadcast_ring_buffer #(
    parameter int BUF_DEPTH   = brb_pkg::DEF_BUF_DEPTH,
    parameter int NUM_READERS = brb_pkg::DEF_NUM_READERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_in
    input  logic [4:0]  i_s_axis_tuser,   // [1:0] op, [4:2] reader
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_out, [16:8] unread_count, rest 0
    output logic        o_m_axis_tuser    // [0] empty_res
);

    logic                        w_item_valid;
    brb_pkg::t_item              w_item;
    logic                        w_pop;
    logic [brb_pkg::DATA_W-1:0]  w_data_out;
    logic [brb_pkg::COUNT_W-1:0] w_count;

    // Request intake and classification.
    brb_front #(
        .NUM_READERS (NUM_READERS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser[1:0]),
        .i_reader     (i_s_axis_tuser[4:2]),
        .i_data       (i_s_axis_tdata),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // Execution: head, reader table, ring memory and response register.
    brb_back #(
        .BUF_DEPTH   (BUF_DEPTH),
        .NUM_READERS (NUM_READERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (w_data_out),
        .o_empty      (o_m_axis_tuser),
        .o_count      (w_count)
    );

    assign o_m_axis_tdata = {7'd0, w_count, w_data_out};

endmodule

[design/brb_checker.sv]
`include "broadcast_ring_buffer_assert.svh"

module brb_checker #(
    parameter int BUF_DEPTH = brb_pkg::DEF_BUF_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled response holds.
    `BRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // Padding above the count is always zero.
    `BRB_ASSERT_IMPLY(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[23:17] == 7'd0)

    // An empty response carries neither a byte nor a count.
    `BRB_ASSERT_IMPLY(a_empty_clean, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[16:0] == 17'd0)

    // The unread count never exceeds the ring depth.
    `BRB_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, o_m_axis_tvalid, (BUF_DEPTH > 511) || (32'(o_m_axis_tdata[16:8]) <= 32'(BUF_DEPTH)))

endmodule

bind broadcast_ring_buffer brb_checker #(
    .BUF_DEPTH (BUF_DEPTH)
) u_brb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/sv/broadcast_ring_buffer_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels of the ring buffer, keeps its own copy of the
// ring, head and reader cursors, and compares every response with the answer
// expected for the oldest outstanding query.
module broadcast_ring_buffer_checker #(
    parameter int BUF_DEPTH   = brb_pkg::DEF_BUF_DEPTH,
    parameter int NUM_READERS = brb_pkg::DEF_NUM_READERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,   // [7:0] data_in
    input  logic [4:0]  i_req_user,   // [1:0] op, [4:2] reader
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [23:0] i_rsp_data,   // [7:0] data_out, [16:8] unread_count, rest 0
    input  logic        i_rsp_user,   // [0] empty_res
    output int          o_error_count,
    output int          o_pending
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

    // One response as the block reports it.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       empty;
        logic [8:0] unread;
    } t_answer;

    // Shadow state of the ring and the reader table.
    logic [7:0]  ring_mem [BUF_DEPTH];
    logic [31:0] head;
    logic [31:0] cursor [NUM_READERS];
    logic        registered [NUM_READERS];
    t_answer     answers_q [$];

    // Counts a failure and shows the first few in detail.
    task automatic note_failure(input string what, input t_answer want, input t_answer got);
        o_error_count++;
        if (o_error_count <= 10) begin
            $display("%0t: %s: expected data 0x%02h empty %0b unread %0d,",
                     $realtime, what, want.byte_val, want.empty, want.unread);
            $display("    got data 0x%02h empty %0b unread %0d",
                     got.byte_val, got.empty, got.unread);
        end
    endtask

    // Applies one accepted request to the shadow state and queues its answer.
    task automatic apply_request(input brb_pkg::t_op op, input logic [2:0] rd,
                                 input logic [7:0] din);
        logic [31:0]   behind;
        t_answer       ans;
        logic [RW-1:0] slot;
        if (op == brb_pkg::OP_PUSH) begin
            ring_mem[AW'(head % BUF_DEPTH)] = din;
            head = head + 32'd1;
        end else begin
            if (rd >= NUM_READERS) begin
                ans = '{8'd0, 1'b1, 9'd0};
            end else begin
                slot = RW'(rd);
                // First access registers the reader at the head.
                if (!registered[slot]) begin
                    registered[slot] = 1'b1;
                    cursor[slot]     = head;
                end
                // A lapped reader restarts at the oldest byte still held.
                behind = head - cursor[slot];
                if (behind > BUF_DEPTH) begin
                    cursor[slot] = head - BUF_DEPTH;
                    behind       = BUF_DEPTH;
                end
                if (op == brb_pkg::OP_AVAIL) begin
                    ans = '{8'd0, (behind == 32'd0), behind[8:0]};
                end else if (behind == 32'd0) begin
                    ans = '{8'd0, 1'b1, 9'd0};
                end else begin
                    ans.byte_val = ring_mem[AW'(cursor[slot] % BUF_DEPTH)];
                    ans.empty    = 1'b0;
                    if (op == brb_pkg::OP_READ) begin
                        cursor[slot] = cursor[slot] + 32'd1;
                        behind       = behind - 32'd1;
                    end
                    ans.unread = behind[8:0];
                end
            end
            answers_q.push_back(ans);
        end
    endtask

    // Responses are checked before the request of the same edge is applied.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                ring_mem[i] = 8'd0;
            end
            for (int i = 0; i < NUM_READERS; i++) begin
                cursor[i]     = 32'd0;
                registered[i] = 1'b0;
            end
            head = 32'd0;
            answers_q.delete();
            o_error_count = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{i_rsp_data[7:0], i_rsp_user, i_rsp_data[16:8]};
                if (answers_q.size() == 0) begin
                    note_failure("response with no query outstanding", '0, got);
                end else begin
                    want = answers_q.pop_front();
                    if (got !== want) begin
                        note_failure("response mismatch", want, got);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(brb_pkg::t_op'(i_req_user[1:0]), i_req_user[4:2], i_req_data);
            end
        end
        o_pending = answers_q.size();
    end

endmodule

[tb/sv/broadcast_ring_buffer_tb.sv]
`timescale 1ns / 1ps

module broadcast_ring_buffer_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_in
    logic [4:0]  i_s_axis_tuser;   // [1:0] op, [4:2] reader
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // [7:0] data_out, [16:8] unread_count, rest 0
    logic        o_m_axis_tuser;   // [0] empty_res

    int   error_count;
    int   pending;
    logic calm;
    logic hold_req;
    logic hold_done;

    broadcast_ring_buffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    broadcast_ring_buffer_checker ring_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .i_req_ready   (o_s_axis_tready),
        .i_req_data    (i_s_axis_tdata),
        .i_req_user    (i_s_axis_tuser),
        .i_rsp_valid   (o_m_axis_tvalid),
        .i_rsp_ready   (i_m_axis_tready),
        .i_rsp_data    (o_m_axis_tdata),
        .i_rsp_user    (o_m_axis_tuser),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Response side: random back-pressure, or one long hold-off on request.
    initial begin
        i_m_axis_tready = 1'b0;
        hold_done       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (199) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!i_rst_n) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Offers one request, with an occasional gap before it, and waits for it
    // to be taken.
    task automatic send_request(input brb_pkg::t_op op, input logic [2:0] rd,
                                input logic [7:0] din);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 15) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= {rd, op};
        i_s_axis_tdata  <= din;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Random request: pushes and reads dominate, readers six and seven are rarely
    // served so that they fall behind.
    task automatic send_random(input logic queries_only);
        int           pick;
        brb_pkg::t_op op;
        logic [2:0]   rd;
        pick = queries_only ? $urandom_range(45, 99) : $urandom_range(0, 99);
        if (pick < 45) begin
            op = brb_pkg::OP_PUSH;
        end else if (pick < 60) begin
            op = brb_pkg::OP_AVAIL;
        end else if (pick < 90) begin
            op = brb_pkg::OP_READ;
        end else begin
            op = brb_pkg::OP_PEEK;
        end
        if ($urandom_range(0, 9) == 0) begin
            rd = 3'($urandom_range(6, 7));
        end else begin
            rd = 3'($urandom_range(0, 5));
        end
        send_request(op, rd, 8'($urandom_range(0, 255)));
    endtask

    // Stops offering until every outstanding query has been answered.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tuser  = 5'd0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // First queries register reader zero against an empty ring.
        send_request(brb_pkg::OP_PEEK,  3'd0, 8'h00);
        send_request(brb_pkg::OP_AVAIL, 3'd0, 8'h00);
        send_request(brb_pkg::OP_READ,  3'd0, 8'h00);
        // Extreme bytes; the reader field is ignored on push.
        send_request(brb_pkg::OP_PUSH,  3'd7, 8'h00);
        send_request(brb_pkg::OP_PUSH,  3'd0, 8'hFF);
        send_request(brb_pkg::OP_PUSH,  3'd5, 8'hA5);
        send_request(brb_pkg::OP_AVAIL, 3'd0, 8'hFF);
        send_request(brb_pkg::OP_PEEK,  3'd0, 8'h00);
        send_request(brb_pkg::OP_READ,  3'd0, 8'h00);
        send_request(brb_pkg::OP_READ,  3'd0, 8'h00);
        send_request(brb_pkg::OP_READ,  3'd0, 8'h00);
        // Reading past the last byte gives an empty answer.
        send_request(brb_pkg::OP_READ,  3'd0, 8'h00);
        send_request(brb_pkg::OP_PEEK,  3'd0, 8'h00);
        // The highest reader slot registers and then sees only newer bytes.
        send_request(brb_pkg::OP_AVAIL, 3'd7, 8'h00);
        send_request(brb_pkg::OP_PUSH,  3'd2, 8'h5A);
        send_request(brb_pkg::OP_PEEK,  3'd7, 8'h00);
        send_request(brb_pkg::OP_READ,  3'd7, 8'h00);
        send_request(brb_pkg::OP_AVAIL, 3'd7, 8'h00);
        send_request(brb_pkg::OP_AVAIL, 3'd0, 8'h00);

        // Random traffic, the first stretch without any idling.
        calm = 1'b1;
        for (int i = 0; i < 160; i++) begin
            if (i == 80) calm = 1'b0;
            send_random(1'b0);
        end

        // Register every reader, then lap them all with a long push burst.
        for (int r = 0; r < 8; r++) begin
            send_request(brb_pkg::OP_AVAIL, 3'(r), 8'h00);
        end
        wait_for_drain();
        calm = 1'b1;
        for (int i = 0; i < 260; i++) begin
            send_request(brb_pkg::OP_PUSH, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
        end
        for (int r = 0; r < 8; r++) begin
            send_request(brb_pkg::OP_AVAIL, 3'(r), 8'h00);
            send_request(brb_pkg::OP_PEEK,  3'(r), 8'h00);
            send_request(brb_pkg::OP_READ,  3'(r), 8'h00);
        end
        calm = 1'b0;
        wait_for_drain();

        // Long response hold-off while queries keep coming, so the input stalls.
        @(posedge i_clk);
        hold_req = 1'b1;
        for (int i = 0; i < 152; i++) begin
            send_random(i < 12);
        end

        wait_for_drain();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
